// File: sv/chfp_pkg.sv
package chfp_pkg;

	// Field widths
	localparam int BYTE_W    = 8;
	localparam int VALUE_W   = 16;
	localparam int KIND_W    = 4;
	localparam int COUNT_W   = 17;
	localparam int NIBBLE_W  = 4;

	// Result buffer sizing: at most four results per input byte
	localparam int MAX_RES   = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = RES_IDX_W + 1;

	// Option nibble codes and token limit
	localparam logic [NIBBLE_W-1:0] NIB_EXT8     = 4'd13;
	localparam logic [NIBBLE_W-1:0] NIB_EXT16    = 4'd14;
	localparam logic [NIBBLE_W-1:0] NIB_RESERVED = 4'd15;
	localparam logic [NIBBLE_W-1:0] TOKEN_MAX    = 4'd8;
	localparam logic [BYTE_W-1:0]   MARKER_BYTE  = 8'hFF;

	// Offsets added to extended option lengths
	localparam logic [COUNT_W-1:0] EXT8_BIAS  = 17'd13;
	localparam logic [COUNT_W-1:0] EXT16_BIAS = 17'd269;

	// Error codes carried in the value of an error result
	localparam logic [VALUE_W-1:0] ERR_RESERVED   = 16'd0;
	localparam logic [VALUE_W-1:0] ERR_TOKEN_LONG = 16'd1;
	localparam logic [VALUE_W-1:0] ERR_TRUNCATED  = 16'd2;

	// Parser position within the message
	typedef enum logic [13:0] {
		PH_HDR0    = 14'b00000000000001,
		PH_HDR1    = 14'b00000000000010,
		PH_HDR2    = 14'b00000000000100,
		PH_HDR3    = 14'b00000000001000,
		PH_TOKEN   = 14'b00000000010000,
		PH_OPT     = 14'b00000000100000,
		PH_DX1     = 14'b00000001000000,
		PH_DX2A    = 14'b00000010000000,
		PH_DX2B    = 14'b00000100000000,
		PH_LX1     = 14'b00001000000000,
		PH_LX2A    = 14'b00010000000000,
		PH_LX2B    = 14'b00100000000000,
		PH_VALUE   = 14'b01000000000000,
		PH_PAYLOAD = 14'b10000000000000
	} phase_t;

	// Kind of a reported field
	typedef enum logic [KIND_W-1:0] {
		KIND_VER      = 4'd0,
		KIND_TYPE     = 4'd1,
		KIND_TOKLEN   = 4'd2,
		KIND_CODE     = 4'd3,
		KIND_MSGID    = 4'd4,
		KIND_TOKBYTE  = 4'd5,
		KIND_DELTA    = 4'd6,
		KIND_LEN      = 4'd7,
		KIND_EXTDELTA = 4'd8,
		KIND_EXTLEN   = 4'd9,
		KIND_VALBYTE  = 4'd10,
		KIND_MARKER   = 4'd11,
		KIND_ERROR    = 4'd12
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [VALUE_W-1:0]  value;
	} result_t;

endpackage

// File: sv/coap_header_field_parser_unit.sv
// Channel  | Signals                           | Beat contents (lowest bit up)
// ---------+-----------------------------------+---------------------------------------
// s_axis   | tvalid tready tdata tlast         | tdata: data_byte[7:0]; tlast: final_byte
// m_axis   | tvalid tready tdata tuser tlast   | tdata: field_value[15:0];
//          |                                   | tuser: field_kind[3:0], message_done, 0
//          |                                   | tlast: last_of_run
//
// A byte is decoded from the input register into a four-entry result buffer. One byte is
// taken per cycle while each byte yields at most one result and the output is not stalled; a byte
// that yields k results holds back the next byte until its k results have left through the single
// result port. A byte passes the input register, then the result buffer, before its first result.
// arst_n clears the parser to expect the first header byte of a new message.
// A stalled output holds the buffer; a byte yielding no result is still taken meanwhile.
module coap_header_field_parser_unit
	import chfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [BYTE_W-1:0]    s_axis_tdata,  // [7:0] data_byte
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [VALUE_W-1:0]   m_axis_tdata,  // [15:0] field_value
	output logic [7:0]           m_axis_tuser,  // [3:0] field_kind, [4] message_done, [7:5] zero
	output logic                 m_axis_tlast
);

	// Input register
	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 last_s1;

	// Parser state
	phase_t               phase_q;
	logic [COUNT_W-1:0]   left_q;
	logic [NIBBLE_W-1:0]  delta_q;
	logic [NIBBLE_W-1:0]  length_q;
	logic [BYTE_W-1:0]    acc_q;
	logic                 disc_q;

	// Result buffer
	result_t              res_q [MAX_RES];
	logic                 obuf_valid_q;
	logic [RES_IDX_W-1:0] rd_q;
	logic [RES_IDX_W-1:0] last_idx_q;
	logic                 done_q;

	// Decode outputs
	phase_t               phase_d;
	logic [COUNT_W-1:0]   left_d;
	logic [NIBBLE_W-1:0]  delta_d;
	logic [NIBBLE_W-1:0]  length_d;
	logic [BYTE_W-1:0]    acc_d;
	logic                 disc_d;
	result_t              res [MAX_RES];
	logic [RES_CNT_W-1:0] res_n;

	logic                 in_acc;
	logic                 out_acc;
	logic                 buf_free;
	logic                 consume;

	// Handshake
	assign out_acc       = obuf_valid_q && m_axis_tready;
	assign buf_free      = !obuf_valid_q || (out_acc && (rd_q == last_idx_q));
	assign consume       = valid_s1 && ((res_n == '0) || buf_free);
	assign s_axis_tready = !valid_s1 || consume;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Decode one byte against the parser state
	always_comb begin
		logic               err;
		logic [COUNT_W-1:0] cnt;
		logic [COUNT_W-1:0] dec;
		logic [NIBBLE_W-1:0] dn;
		logic [NIBBLE_W-1:0] ln;

		phase_d  = phase_q;
		left_d   = left_q;
		delta_d  = delta_q;
		length_d = length_q;
		acc_d    = acc_q;
		disc_d   = disc_q;
		err      = 1'b0;
		res_n    = '0;
		cnt      = '0;
		dec      = '0;
		dn       = byte_s1[7:4];
		ln       = byte_s1[3:0];
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '{kind: KIND_VER, value: '0};
		end

		if (!disc_q) begin
			case (phase_q)
				PH_HDR0: begin
					res[0] = '{kind: KIND_VER, value: VALUE_W'(byte_s1[7:6])};
					res[1] = '{kind: KIND_TYPE, value: VALUE_W'(byte_s1[5:4])};
					res[2] = '{kind: KIND_TOKLEN, value: VALUE_W'(byte_s1[3:0])};
					res_n  = RES_CNT_W'(3);
					left_d = COUNT_W'(byte_s1[3:0]);
					if (byte_s1[3:0] > TOKEN_MAX) begin
						res[3] = '{kind: KIND_ERROR, value: ERR_TOKEN_LONG};
						res_n  = RES_CNT_W'(4);
						err    = 1'b1;
					end else begin
						phase_d = PH_HDR1;
					end
				end
				PH_HDR1: begin
					res[0]  = '{kind: KIND_CODE, value: VALUE_W'(byte_s1)};
					res_n   = RES_CNT_W'(1);
					phase_d = PH_HDR2;
				end
				PH_HDR2: begin
					acc_d   = byte_s1;
					phase_d = PH_HDR3;
				end
				PH_HDR3: begin
					res[0]  = '{kind: KIND_MSGID, value: {acc_q, byte_s1}};
					res_n   = RES_CNT_W'(1);
					phase_d = (left_q != '0) ? PH_TOKEN : PH_OPT;
				end
				PH_TOKEN, PH_VALUE: begin
					res[0] = '{kind: (phase_q == PH_TOKEN) ? KIND_TOKBYTE : KIND_VALBYTE,
						value: VALUE_W'(byte_s1)};
					res_n  = RES_CNT_W'(1);
					dec    = (left_q != '0) ? left_q - 1'b1 : left_q;
					left_d = dec;
					if (dec == '0) begin
						phase_d = PH_OPT;
					end
				end
				PH_OPT: begin
					if (byte_s1 == MARKER_BYTE) begin
						res[0]  = '{kind: KIND_MARKER, value: VALUE_W'(byte_s1)};
						res_n   = RES_CNT_W'(1);
						phase_d = PH_PAYLOAD;
					end else begin
						delta_d  = dn;
						length_d = ln;
						res[0]   = '{kind: KIND_DELTA, value: VALUE_W'(dn)};
						res[1]   = '{kind: KIND_LEN, value: VALUE_W'(ln)};
						res_n    = RES_CNT_W'(2);
						if (dn == NIB_RESERVED || ln == NIB_RESERVED) begin
							res[2] = '{kind: KIND_ERROR, value: ERR_RESERVED};
							res_n  = RES_CNT_W'(3);
							err    = 1'b1;
						end else if (dn == NIB_EXT8) begin
							phase_d = PH_DX1;
						end else if (dn == NIB_EXT16) begin
							phase_d = PH_DX2A;
						end else if (ln == NIB_EXT8) begin
							phase_d = PH_LX1;
						end else if (ln == NIB_EXT16) begin
							phase_d = PH_LX2A;
						end else begin
							left_d  = COUNT_W'(ln);
							phase_d = (ln != '0) ? PH_VALUE : PH_OPT;
						end
					end
				end
				PH_DX1, PH_DX2B: begin
					res[0] = '{kind: KIND_EXTDELTA,
						value: (phase_q == PH_DX1) ? VALUE_W'(byte_s1) : {acc_q, byte_s1}};
					res_n  = RES_CNT_W'(1);
					// Move on to the length part of the option
					if (length_q == NIB_EXT8) begin
						phase_d = PH_LX1;
					end else if (length_q == NIB_EXT16) begin
						phase_d = PH_LX2A;
					end else begin
						left_d  = COUNT_W'(length_q);
						phase_d = (length_q != '0) ? PH_VALUE : PH_OPT;
					end
				end
				PH_DX2A: begin
					acc_d   = byte_s1;
					phase_d = PH_DX2B;
				end
				PH_LX2A: begin
					acc_d   = byte_s1;
					phase_d = PH_LX2B;
				end
				PH_LX1, PH_LX2B: begin
					if (phase_q == PH_LX1) begin
						res[0] = '{kind: KIND_EXTLEN, value: VALUE_W'(byte_s1)};
						cnt    = COUNT_W'(byte_s1) + EXT8_BIAS;
					end else begin
						res[0] = '{kind: KIND_EXTLEN, value: {acc_q, byte_s1}};
						cnt    = COUNT_W'({acc_q, byte_s1}) + EXT16_BIAS;
					end
					res_n   = RES_CNT_W'(1);
					left_d  = cnt;
					phase_d = (cnt != '0) ? PH_VALUE : PH_OPT;
				end
				PH_PAYLOAD: begin
					// Drop payload bytes
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase

			// Flag an error or a message cut short
			if (err) begin
				if (!last_s1) begin
					disc_d = 1'b1;
				end
			end else if (last_s1 && phase_d != PH_OPT && phase_d != PH_PAYLOAD) begin
				res[res_n[RES_IDX_W-1:0]] = '{kind: KIND_ERROR, value: ERR_TRUNCATED};
				res_n = res_n + 1'b1;
			end
		end

		// Restart on the final byte of a message
		if (last_s1) begin
			phase_d  = PH_HDR0;
			left_d   = '0;
			delta_d  = '0;
			length_d = '0;
			acc_d    = '0;
			disc_d   = 1'b0;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Advance parser state as each byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			left_q   <= '0;
			delta_q  <= '0;
			length_q <= '0;
			acc_q    <= '0;
			disc_q   <= 1'b0;
		end else if (consume) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			delta_q  <= delta_d;
			length_q <= length_d;
			acc_q    <= acc_d;
			disc_q   <= disc_d;
		end
	end

	// Result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_valid_q <= 1'b0;
			rd_q         <= '0;
			last_idx_q   <= '0;
			done_q       <= 1'b0;
		end else if (consume && res_n != '0) begin
			obuf_valid_q <= 1'b1;
			rd_q         <= '0;
			last_idx_q   <= RES_IDX_W'(res_n - 1'b1);
			done_q       <= last_s1;
		end else if (out_acc) begin
			if (rd_q == last_idx_q) begin
				obuf_valid_q <= 1'b0;
			end else begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	// Hold the results of one byte
	always_ff @(posedge clk) begin
		if (consume && res_n != '0) begin
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= res[i];
			end
		end
	end

	// Drive the output beat
	assign m_axis_tvalid = obuf_valid_q;
	assign m_axis_tdata  = res_q[rd_q].value;
	assign m_axis_tlast  = (rd_q == last_idx_q);
	assign m_axis_tuser  = {3'b000, done_q && (rd_q == last_idx_q), res_q[rd_q].kind};

endmodule

// File: dv/coap_header_field_parser_unit_tb.sv
module coap_header_field_parser_unit_tb
	import chfp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BEATS = 170;
	localparam int CALM_AFTER   = 140;
	localparam int LONG_HOLD    = 80;
	localparam int FILL_BEATS   = 20;

	// One decoded header field as it should leave the block
	typedef struct {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		bit                 run_end;
		bit                 msg_end;
	} field_t;

	// Tracks the parser position and queues the fields each byte should yield
	class field_tracker;
		phase_t             ph;
		logic [COUNT_W-1:0] remaining;
		logic [3:0]         delta_nib;
		logic [3:0]         len_nib;
		logic [7:0]         high_byte;
		bit                 dropping;
		field_t             fresh[$];
		field_t             pending_fields[$];
		int                 mismatches;

		function new();
			clear();
			mismatches = 0;
		endfunction

		function void clear();
			ph        = PH_HDR0;
			remaining = '0;
			delta_nib = '0;
			len_nib   = '0;
			high_byte = '0;
			dropping  = 1'b0;
		endfunction

		function void add(kind_t k, logic [VALUE_W-1:0] v);
			field_t f;
			f.kind    = k;
			f.value   = v;
			f.run_end = 1'b0;
			f.msg_end = 1'b0;
			fresh.push_back(f);
		endfunction

		function void open_value(logic [COUNT_W-1:0] n);
			remaining = n;
			if (n != 0)
				ph = PH_VALUE;
			else
				ph = PH_OPT;
		endfunction

		function void after_delta();
			if (len_nib == NIB_EXT8)
				ph = PH_LX1;
			else if (len_nib == NIB_EXT16)
				ph = PH_LX2A;
			else
				open_value(COUNT_W'(len_nib));
		endfunction

		function void report(string what);
			$display("%0t ns mismatch: %s", $time, what);
			mismatches++;
		endfunction

		function int outstanding();
			return pending_fields.size();
		endfunction

		// Advance the parser by one accepted beat and queue what it yields
		function void take_byte(logic [7:0] b, bit fin);
			bit                 err;
			logic [VALUE_W-1:0] word;
			err = 1'b0;
			fresh.delete();
			if (dropping) begin
				if (fin)
					clear();
				return;
			end
			case (ph)
				PH_HDR0: begin
					add(KIND_VER, VALUE_W'(b[7:6]));
					add(KIND_TYPE, VALUE_W'(b[5:4]));
					add(KIND_TOKLEN, VALUE_W'(b[3:0]));
					remaining = COUNT_W'(b[3:0]);
					if (b[3:0] > TOKEN_MAX) begin
						add(KIND_ERROR, ERR_TOKEN_LONG);
						err = 1'b1;
					end else begin
						ph = PH_HDR1;
					end
				end
				PH_HDR1: begin
					add(KIND_CODE, VALUE_W'(b));
					ph = PH_HDR2;
				end
				PH_HDR2: begin
					high_byte = b;
					ph = PH_HDR3;
				end
				PH_HDR3: begin
					add(KIND_MSGID, {high_byte, b});
					if (remaining != 0)
						ph = PH_TOKEN;
					else
						ph = PH_OPT;
				end
				PH_TOKEN, PH_VALUE: begin
					if (ph == PH_TOKEN)
						add(KIND_TOKBYTE, VALUE_W'(b));
					else
						add(KIND_VALBYTE, VALUE_W'(b));
					if (remaining != 0)
						remaining--;
					if (remaining == 0)
						ph = PH_OPT;
				end
				PH_OPT: begin
					if (b == MARKER_BYTE) begin
						add(KIND_MARKER, VALUE_W'(b));
						ph = PH_PAYLOAD;
					end else begin
						delta_nib = b[7:4];
						len_nib   = b[3:0];
						add(KIND_DELTA, VALUE_W'(delta_nib));
						add(KIND_LEN, VALUE_W'(len_nib));
						if (delta_nib == NIB_RESERVED || len_nib == NIB_RESERVED) begin
							add(KIND_ERROR, ERR_RESERVED);
							err = 1'b1;
						end else if (delta_nib == NIB_EXT8) begin
							ph = PH_DX1;
						end else if (delta_nib == NIB_EXT16) begin
							ph = PH_DX2A;
						end else begin
							after_delta();
						end
					end
				end
				PH_DX1: begin
					add(KIND_EXTDELTA, VALUE_W'(b));
					after_delta();
				end
				PH_DX2A: begin
					high_byte = b;
					ph = PH_DX2B;
				end
				PH_LX2A: begin
					high_byte = b;
					ph = PH_LX2B;
				end
				PH_DX2B: begin
					add(KIND_EXTDELTA, {high_byte, b});
					after_delta();
				end
				PH_LX1: begin
					add(KIND_EXTLEN, VALUE_W'(b));
					open_value(COUNT_W'(b) + EXT8_BIAS);
				end
				PH_LX2B: begin
					word = {high_byte, b};
					add(KIND_EXTLEN, word);
					open_value(COUNT_W'(word) + EXT16_BIAS);
				end
				default: begin
				end
			endcase

			// Errors before the final beat start a discard; an unfinished message on its final beat is truncated
			if (err) begin
				if (!fin)
					dropping = 1'b1;
			end else if (fin && ph != PH_OPT && ph != PH_PAYLOAD) begin
				add(KIND_ERROR, ERR_TRUNCATED);
			end
			if (fin)
				clear();

			if (fresh.size() > 0) begin
				fresh[fresh.size()-1].run_end = 1'b1;
				fresh[fresh.size()-1].msg_end = fin;
			end
			foreach (fresh[i])
				pending_fields.push_back(fresh[i]);
		endfunction

		// Compare one output beat against the oldest queued field
		function void match_field(logic [3:0] kind, logic [VALUE_W-1:0] value,
		                          logic run_end, logic msg_end, logic [2:0] spare);
			field_t want;
			if (pending_fields.size() == 0) begin
				report($sformatf("unexpected beat kind %0d value %h last %b done %b",
				                 kind, value, run_end, msg_end));
				return;
			end
			want = pending_fields.pop_front();
			if (kind !== want.kind || value !== want.value || run_end !== want.run_end ||
			    msg_end !== want.msg_end || spare !== 3'b000)
				report($sformatf({"got kind %0d value %h last %b done %b spare %b, ",
				                  "want kind %0d value %h last %b done %b"},
				                 kind, value, run_end, msg_end, spare,
				                 want.kind, want.value, want.run_end, want.msg_end));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [BYTE_W-1:0]  s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [VALUE_W-1:0] m_axis_tdata;
	logic [7:0]         m_axis_tuser;
	logic               m_axis_tlast;

	field_tracker tracker = new();
	logic [7:0]   msg_data[$];
	int           beats_sent = 0;
	int           base_count;
	bit           calm = 1'b0;
	bit           hold_once = 1'b0;

	coap_header_field_parser_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Note input beats and check output beats at the same edge, inputs first
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				tracker.match_field(m_axis_tuser[3:0], m_axis_tdata, m_axis_tlast,
				                    m_axis_tuser[4], m_axis_tuser[7:5]);
		end
	end

	// Receiver: random stall bursts, one long hold-off, then steady
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_once) begin
				hold_once = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one beat, with an occasional gap ahead of it, and hold until taken
	task automatic send_byte(input logic [7:0] b, input bit fin);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_message();
		foreach (msg_data[i])
			send_byte(msg_data[i], i == msg_data.size() - 1);
	endtask

	// Build a random message: mostly well formed, some cut short, some broken
	function automatic void build_message();
		int   pick;
		int   tkl;
		int   dn;
		int   ln;
		int   nval;
		int   cut;
		int   sel;
		bit   open_end;
		logic [7:0] hi;
		logic [7:0] lo;
		msg_data.delete();
		open_end = 1'b0;
		pick = $urandom_range(0, 99);

		// plain noise
		if (pick >= 93) begin
			repeat ($urandom_range(1, 8)) msg_data.push_back(8'($urandom));
			return;
		end
		// token length over the limit
		if (pick >= 85) begin
			msg_data.push_back({2'($urandom), 2'($urandom), 4'($urandom_range(9, 15))});
			repeat ($urandom_range(0, 4)) msg_data.push_back(8'($urandom));
			return;
		end

		tkl = $urandom_range(0, 8);
		msg_data.push_back({2'($urandom), 2'($urandom), 4'(tkl)});
		repeat (3 + tkl) msg_data.push_back(8'($urandom));

		// reserved nibble in either half of the option byte
		if (pick >= 75) begin
			if ($urandom_range(0, 1)) begin
				dn = 15;
				ln = $urandom_range(0, 14);
			end else begin
				dn = $urandom_range(0, 14);
				ln = 15;
			end
			msg_data.push_back({4'(dn), 4'(ln)});
			repeat ($urandom_range(0, 4)) msg_data.push_back(8'($urandom));
			return;
		end

		repeat ($urandom_range(0, 4)) begin
			if (!open_end) begin
				sel = $urandom_range(0, 9);
				dn = (sel < 7) ? $urandom_range(0, 12) : (sel < 9) ? 13 : 14;
				sel = $urandom_range(0, 19);
				ln = (sel < 14) ? $urandom_range(0, 4) : (sel < 15) ? $urandom_range(5, 12) :
				     (sel < 18) ? 13 : 14;
				msg_data.push_back({4'(dn), 4'(ln)});
				if (dn == 13)
					msg_data.push_back(8'($urandom));
				else if (dn == 14)
					repeat (2) msg_data.push_back(8'($urandom));
				nval = ln;
				if (ln == 13) begin
					lo = $urandom_range(0, 1) ? 8'($urandom_range(0, 6)) : 8'($urandom);
					msg_data.push_back(lo);
					nval = int'(lo) + int'(EXT8_BIAS);
				end else if (ln == 14) begin
					hi = 8'($urandom);
					lo = 8'($urandom);
					msg_data.push_back(hi);
					msg_data.push_back(lo);
					nval = int'({hi, lo}) + int'(EXT16_BIAS);
				end
				// long values end the message part way through
				if (nval > 20) begin
					open_end = 1'b1;
					nval = $urandom_range(0, 5);
				end
				repeat (nval) msg_data.push_back(8'($urandom));
			end
		end

		if (!open_end && $urandom_range(0, 1)) begin
			msg_data.push_back(MARKER_BYTE);
			repeat ($urandom_range(0, 4)) msg_data.push_back(8'($urandom));
		end

		// cut a well-formed message at a random point
		if (pick >= 60) begin
			cut = $urandom_range(1, msg_data.size());
			while (msg_data.size() > cut)
				void'(msg_data.pop_back());
		end
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// header only, ending cleanly
		msg_data = '{8'h40, 8'h01, 8'h12, 8'h34};
		send_message();
		// top header values, one token byte, 16-bit delta, marker, payload to the end
		msg_data = '{8'hF1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hE0, 8'h12, 8'h34, 8'hFF, 8'h00};
		send_message();
		// token length over the limit, then dropped bytes up to and including the final one
		msg_data = '{8'h4F, 8'h00, 8'h00};
		send_message();
		// reserved length nibble on the final byte itself
		msg_data = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h0F};
		msg_data = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h0F};
		send_message();
		// message ends inside the header
		msg_data = '{8'h40, 8'h00};
		send_message();

		// fill the block while the receiver is held off; the 16-bit length outruns the message
		hold_once = 1'b1;
		msg_data = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h0E, 8'h01, 8'h00};
		repeat (FILL_BEATS) msg_data.push_back(8'($urandom));
		send_message();

		base_count = beats_sent;
		while (beats_sent - base_count < RANDOM_BEATS) begin
			if (beats_sent - base_count >= CALM_AFTER)
				calm = 1'b1;
			build_message();
			send_message();
		end
		s_axis_tvalid <= 1'b0;

		// drain, then allow for stray beats
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("coap_header_field_parser_unit_tb: done, clean");
		else
			$display("coap_header_field_parser_unit_tb: done, errors");
		$finish;
	end

	// Give up on a hang
	initial begin
		#2_000_000;
		$display("coap_header_field_parser_unit_tb: done, errors");
		$finish;
	end

endmodule
